[hw/rtl/nearest_blob_tracker_assert.svh]
`ifndef NEAREST_BLOB_TRACKER_ASSERT_SVH
`define NEAREST_BLOB_TRACKER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define NBT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nearest_blob_tracker assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define NBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nearest_blob_tracker assertion failed");

`endif

[hw/rtl/nbt_pkg.sv]
package nbt_pkg;

  localparam int unsigned X_W            = 10;
  localparam int unsigned Y_W            = 9;
  localparam int unsigned ID_W           = 16;
  localparam int unsigned RAD_W          = 11;
  localparam int unsigned RADIUS_RESET   = 75;
  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned IDX_OUT_W      = 6;
  localparam int unsigned IDX_MAX_W      = 8;
  localparam int unsigned CNT_MAX_W      = 9;
  // Squared distance width, rounded up to even so the root has S_W/2 digits.
  localparam int unsigned S_W            = 22;

  typedef struct packed {
    logic [X_W-1:0] point_x;
    logic [Y_W-1:0] point_y;
    logic           frame_empty;
    logic           end_of_frame;
  } in_word_t;

  typedef struct packed {
    logic                 matched;
    logic [IDX_OUT_W-1:0] match_index;
    logic [ID_W-1:0]      blob_id;
    logic                 capacity_overflow;
    logic                 frame_done;
  } out_word_t;

  typedef struct packed {
    logic                 found;
    logic [RAD_W-1:0]     best;
    logic [IDX_MAX_W-1:0] idx;
    logic [ID_W-1:0]      id;
  } chain_t;

  typedef struct packed {
    logic                 sq_en;
    logic                 root_en;
    logic [S_W-1:0]       root_bit;
    logic                 chain_en;
    logic                 wr_en;
    logic [IDX_MAX_W-1:0] wr_idx;
    logic                 close;
    logic [X_W-1:0]       qx;
    logic [Y_W-1:0]       qy;
    logic [ID_W-1:0]      wid;
    logic [CNT_MAX_W-1:0] prev_count;
  } cell_ctl_t;

endpackage

[hw/rtl/nbt_cell.sv]
module nbt_cell
  import nbt_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  chain_t    chain_i,
  output chain_t    chain_o
);

  logic [X_W-1:0]     cur_x_q, prev_x_q;
  logic [Y_W-1:0]     cur_y_q, prev_y_q;
  logic [ID_W-1:0]    cur_id_q, prev_id_q;
  logic [S_W-1:0]     rem_q, root_q;
  chain_t             chain_q, chain_d;
  logic [X_W-1:0]     dx;
  logic [Y_W-1:0]     dy;
  logic [2*X_W-1:0]   dxx;
  logic [2*Y_W-1:0]   dyy;
  logic [S_W-1:0]     trial;
  logic               sel;
  logic               in_range;
  logic               take;

  assign sel      = ctl_i.wr_en && (ctl_i.wr_idx == IDX_MAX_W'(INDEX));
  assign dx       = (ctl_i.qx >= prev_x_q) ? ctl_i.qx - prev_x_q : prev_x_q - ctl_i.qx;
  assign dy       = (ctl_i.qy >= prev_y_q) ? ctl_i.qy - prev_y_q : prev_y_q - ctl_i.qy;
  assign dxx      = dx * dx;
  assign dyy      = dy * dy;
  assign trial    = root_q + ctl_i.root_bit;
  assign in_range = CNT_MAX_W'(INDEX) < ctl_i.prev_count;
  assign take     = in_range && (root_q[RAD_W-1:0] <= chain_i.best);

  always_comb begin
    chain_d = chain_i;
    if (take) begin
      chain_d.found = 1'b1;
      chain_d.best  = root_q[RAD_W-1:0];
      chain_d.idx   = IDX_MAX_W'(INDEX);
      chain_d.id    = prev_id_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel) begin
      cur_x_q  <= ctl_i.qx;
      cur_y_q  <= ctl_i.qy;
      cur_id_q <= ctl_i.wid;
    end
    if (ctl_i.close) begin
      prev_x_q  <= sel ? ctl_i.qx  : cur_x_q;
      prev_y_q  <= sel ? ctl_i.qy  : cur_y_q;
      prev_id_q <= sel ? ctl_i.wid : cur_id_q;
    end
    if (ctl_i.sq_en) begin
      rem_q  <= S_W'(dxx) + S_W'(dyy);
      root_q <= '0;
    end else if (ctl_i.root_en) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + ctl_i.root_bit;
      end else begin
        root_q <= root_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else if (ctl_i.chain_en) begin
      chain_q <= chain_d;
    end
  end

  assign chain_o = chain_q;

endmodule

[hw/rtl/nearest_blob_tracker.sv]
// An accepted point word passes through these steps in order: ST_SQ forms the squared
// distances, ST_ROOT takes the roots digit by digit in every cell, ST_CHAIN passes the
// running best down the cell row, and ST_FIN loads the result register once the output
// can take it. The input stalls until then, so a new point word is taken only after the
// last one's result is loaded; an empty word does not stall the input.
// Reset clears the point counts, the ID counter and the handshake; radius resets to 75.
module nearest_blob_tracker
  import nbt_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o,
  input  logic             cfg_we_i,
  input  logic [RAD_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQ    = 3'd1;
  localparam logic [2:0] ST_ROOT  = 3'd2;
  localparam logic [2:0] ST_CHAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [S_W-1:0]   bit_q, bit_d;
  in_word_t         q_q;
  logic [RAD_W-1:0] radius_q;
  logic [CNT_W-1:0] cur_count_q, cur_count_d, prev_count_q, prev_count_d;
  logic [ID_W-1:0]  id_cnt_q, id_cnt_d;
  out_word_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             in_fire, fin_fire, store;
  logic [ID_W-1:0]  new_id;
  cell_ctl_t        ctl;
  chain_t           links [MAX_POINTS+1];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign fin_fire    = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign store       = cur_count_q < CNT_W'(MAX_POINTS);
  assign new_id      = links[MAX_POINTS].found ? links[MAX_POINTS].id : id_cnt_q + 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign links[0] = '{found: 1'b0, best: radius_q, idx: '0, id: '0};

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    nbt_cell #(.INDEX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .chain_i (links[i]),
      .chain_o (links[i+1])
    );
  end

  always_comb begin
    ctl            = '0;
    ctl.sq_en      = (state_q == ST_SQ);
    ctl.root_en    = (state_q == ST_ROOT);
    ctl.root_bit   = bit_q;
    ctl.chain_en   = (state_q == ST_CHAIN);
    ctl.wr_en      = fin_fire && store;
    ctl.wr_idx     = IDX_MAX_W'(cur_count_q);
    ctl.close      = (in_fire && in_word_i.frame_empty && in_word_i.end_of_frame) ||
                     (fin_fire && q_q.end_of_frame);
    ctl.qx         = q_q.point_x;
    ctl.qy         = q_q.point_y;
    ctl.wid        = new_id;
    ctl.prev_count = CNT_MAX_W'(prev_count_q);
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    bit_d        = bit_q;
    cur_count_d  = cur_count_q;
    prev_count_d = prev_count_q;
    id_cnt_d     = id_cnt_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && !in_word_i.frame_empty) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        bit_d   = S_W'(1) << (S_W - 2);
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          step_d  = '0;
          state_d = ST_CHAIN;
        end
      end
      ST_CHAIN: begin
        step_d = step_q + 1'b1;
        if (step_q == IDX_W'(MAX_POINTS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_fire) begin
          state_d                 = ST_IDLE;
          out_valid_d             = 1'b1;
          out_d.matched           = links[MAX_POINTS].found;
          out_d.match_index       = links[MAX_POINTS].idx[IDX_OUT_W-1:0];
          out_d.blob_id           = new_id;
          out_d.capacity_overflow = !store;
          out_d.frame_done        = q_q.end_of_frame;
          if (!links[MAX_POINTS].found) begin
            id_cnt_d = new_id;
          end
          if (store) begin
            cur_count_d = cur_count_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (ctl.close) begin
      prev_count_d = (fin_fire && store) ? cur_count_q + 1'b1 : cur_count_q;
      cur_count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      radius_q     <= RAD_W'(RADIUS_RESET);
      cur_count_q  <= '0;
      prev_count_q <= '0;
      id_cnt_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_count_q  <= cur_count_d;
      prev_count_q <= prev_count_d;
      id_cnt_q     <= id_cnt_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    bit_q  <= bit_d;
    out_q  <= out_d;
    if (in_fire) begin
      q_q <= in_word_i;
    end
  end

endmodule

[hw/rtl/nbt_checker.sv]
`include "nearest_blob_tracker_assert.svh"

module nbt_checker
  import nbt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // A waiting result word holds until it is taken.
  `NBT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))
  // A point word keeps the input stalled while it is being matched.
  `NBT_ASSERT_NEXT(a_busy, in_valid_i && !in_stall_o && !in_word_i.frame_empty, in_stall_o)
  // An unmatched point reports index zero.
  `NBT_ASSERT_NOW(a_idx_zero, out_valid_o && !out_word_o.matched, out_word_o.match_index == '0)
  // An empty word produces no result in the following cycle.
  `NBT_ASSERT_NEXT(a_empty, in_valid_i && !in_stall_o && in_word_i.frame_empty && !out_valid_o,
                   !out_valid_o)

endmodule

bind nearest_blob_tracker nbt_checker u_nbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
